// File: rtl/tlvp_pkg.sv
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types and constants of the tag/length/value record parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

	// entries a section may hold
	localparam int MAX_ENTRIES = 4096;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CFG_W       = 13;
	localparam int EFF_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// decoupling queue between parser and output stage
	localparam int FIFO_DEPTH = 4;

	// record kinds
	localparam logic [3:0] KIND_LEN  = 4'd0;
	localparam logic [3:0] KIND_HASH = 4'd3;
	localparam logic [3:0] KIND_SOFF = 4'd8;
	localparam logic [3:0] KIND_END  = 4'd9;

	// fault codes
	localparam logic [2:0] FAULT_NONE  = 3'd0;
	localparam logic [2:0] FAULT_EMPTY = 3'd1;
	localparam logic [2:0] FAULT_HASH  = 3'd2;
	localparam logic [2:0] FAULT_SOFF  = 3'd3;
	localparam logic [2:0] FAULT_TAG   = 3'd4;

	localparam logic [15:0] HASH_BYTES = 16'd32;
	localparam logic [15:0] SOFF_BYTES = 16'd8;

	// tags as little-endian 32-bit words
	localparam logic [31:0] TAG_END = {"T", "D", "N", "E"};
	localparam logic [31:0] KNOWN_TAGS [8] = '{
		{"E", "M", "A", "N"}, {"E", "P", "Y", "T"},
		{"H", "S", "A", "H"}, {"Z", "S", "D", "M"},
		{"T", "F", "F", "O"}, {"S", "R", "E", "V"},
		{"S", "S", "E", "T"}, {"F", "F", "O", "S"}
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       section_start;
	} tlvp_in_t;

	typedef struct packed {
		logic [11:0] entry_number;
		logic [3:0]  record_kind;
		logic [12:0] word_number;
		logic [63:0] word_data;
		logic [3:0]  valid_bytes;
		logic        record_last;
		logic [2:0]  fault_code;
		logic        section_done;
	} tlvp_out_t;

	typedef enum logic [1:0] {
		EV_LEN   = 2'd0,
		EV_WORD  = 2'd1,
		EV_END   = 2'd2,
		EV_FAULT = 2'd3
	} tlvp_ev_code_t;

	// compact event from parser to output stage
	typedef struct packed {
		tlvp_ev_code_t code;
		logic [11:0]   entry;
		logic [3:0]    kind;
		logic [12:0]   word;
		logic [63:0]   data;
		logic [3:0]    nbytes;
		logic          last;
		logic [2:0]    fault;
		logic          done;
	} tlvp_ev_t;

	// 0 when the tag is not known
	function automatic logic [3:0] tag_kind(input logic [31:0] tag);
		logic [3:0] k;
		k = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (KNOWN_TAGS[i] == tag) begin
				k = 4'(i + 1);
			end
		end
		return k;
	endfunction

endpackage

// File: rtl/tlvp_front.sv
// ----------------------------------------------------------------------------
// tlvp_front
// Byte parser: assembles lengths and tags, classifies records, cuts payload
// into words and raises one event per result.
// ----------------------------------------------------------------------------
module tlvp_front import tlvp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  tlvp_in_t         item,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             ev_valid,
	output tlvp_ev_t         ev
);

	typedef enum logic [4:0] {
		PH_LEN     = 5'b00001,
		PH_TAG     = 5'b00010,
		PH_TLEN    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	localparam logic [EFF_W-1:0] MAX_EFF = EFF_W'(MAX_ENTRIES);

	logic [CFG_W-1:0] entry_count_q;
	phase_t           phase_q, cur_phase, nxt_phase;
	logic [15:0]      cnt_q, cur_cnt, nxt_cnt;
	logic [31:0]      tag_q, cur_tag, nxt_tag;
	logic [15:0]      plen_q, cur_plen, nxt_plen;
	logic [63:0]      word_q, cur_word, nxt_word;
	logic [12:0]      wctr_q, cur_wctr, nxt_wctr;
	logic [CNT_W-1:0] ectr_q, cur_ectr, nxt_ectr;
	logic [3:0]       kind_q, cur_kind, nxt_kind;
	logic             halted_q, cur_halt, nxt_halt;

	logic [EFF_W-1:0] eff;
	logic [15:0]      cnt_n;
	logic [31:0]      tag_n;
	logic [63:0]      word_n;
	logic [3:0]       kind_n;
	logic [2:0]       mod_n;
	logic             last_n;
	logic             done_n;

	assign eff = (EFF_W'(entry_count_q) < MAX_EFF) ? EFF_W'(entry_count_q) : MAX_EFF;

	// a section start restarts the parser before its byte is parsed
	always_comb begin
		cur_phase = item.section_start ? PH_LEN : phase_q;
		cur_cnt   = item.section_start ? '0 : cnt_q;
		cur_tag   = item.section_start ? '0 : tag_q;
		cur_plen  = item.section_start ? '0 : plen_q;
		cur_word  = item.section_start ? '0 : word_q;
		cur_wctr  = item.section_start ? '0 : wctr_q;
		cur_ectr  = item.section_start ? '0 : ectr_q;
		cur_kind  = item.section_start ? '0 : kind_q;
		cur_halt  = item.section_start ? 1'b0 : halted_q;
	end

	always_comb begin
		nxt_phase = cur_phase;
		nxt_cnt   = cur_cnt;
		nxt_tag   = cur_tag;
		nxt_plen  = cur_plen;
		nxt_word  = cur_word;
		nxt_wctr  = cur_wctr;
		nxt_ectr  = cur_ectr;
		nxt_kind  = cur_kind;
		nxt_halt  = cur_halt;
		ev_valid  = 1'b0;
		ev        = '0;
		ev.entry  = 12'(cur_ectr);
		cnt_n     = cur_cnt + 16'd1;
		tag_n     = cur_tag;
		word_n    = cur_word;
		kind_n    = tag_kind(cur_tag);
		mod_n     = '0;
		last_n    = 1'b0;
		done_n    = 1'b0;
		if (accept && !cur_halt) begin
			unique case (cur_phase)
				PH_LEN: begin
					if (cur_cnt == 16'd0 && EFF_W'(cur_ectr) >= eff) begin
						nxt_phase = PH_DONE;
					end else begin
						tag_n[{cur_cnt[1:0], 3'b000} +: 8] =
							tag_n[{cur_cnt[1:0], 3'b000} +: 8] | item.data_byte;
						nxt_tag = tag_n;
						nxt_cnt = cnt_n;
						if (cnt_n == 16'd4) begin
							ev_valid  = 1'b1;
							ev.code   = EV_LEN;
							ev.kind   = KIND_LEN;
							ev.data   = 64'(tag_n);
							nxt_cnt   = '0;
							nxt_tag   = '0;
							nxt_phase = PH_TAG;
						end
					end
				end
				PH_TAG: begin
					tag_n[{cur_cnt[1:0], 3'b000} +: 8] =
						tag_n[{cur_cnt[1:0], 3'b000} +: 8] | item.data_byte;
					kind_n  = tag_kind(tag_n);
					nxt_tag = tag_n;
					nxt_cnt = cnt_n;
					if (cnt_n == 16'd4) begin
						nxt_cnt = '0;
						nxt_tag = '0;
						if (tag_n == TAG_END) begin
							done_n    = (EFF_W'(cur_ectr) + EFF_W'(1)) >= eff;
							nxt_kind  = KIND_END;
							ev_valid  = 1'b1;
							ev.code   = EV_END;
							ev.kind   = KIND_END;
							ev.done   = done_n;
							nxt_ectr  = cur_ectr + CNT_W'(1);
							nxt_phase = done_n ? PH_DONE : PH_LEN;
						end else begin
							nxt_kind  = kind_n;
							nxt_phase = PH_TLEN;
						end
					end
				end
				PH_TLEN: begin
					tag_n[{cur_cnt[0], 3'b000} +: 8] =
						tag_n[{cur_cnt[0], 3'b000} +: 8] | item.data_byte;
					nxt_tag = tag_n;
					nxt_cnt = cnt_n;
					if (cnt_n == 16'd2) begin
						nxt_plen = tag_n[15:0];
						nxt_cnt  = '0;
						nxt_tag  = '0;
						ev.code  = EV_FAULT;
						ev.kind  = cur_kind;
						// fault priority: empty, unknown tag, then size checks
						if (tag_n[15:0] == 16'd0) begin
							ev.fault = FAULT_EMPTY;
						end else if (cur_kind == KIND_LEN) begin
							ev.fault = FAULT_TAG;
						end else if (cur_kind == KIND_HASH && tag_n[15:0] != HASH_BYTES) begin
							ev.fault = FAULT_HASH;
						end else if (cur_kind == KIND_SOFF && tag_n[15:0] != SOFF_BYTES) begin
							ev.fault = FAULT_SOFF;
						end
						if (ev.fault != FAULT_NONE) begin
							ev_valid = 1'b1;
							nxt_halt = 1'b1;
						end else begin
							nxt_word  = '0;
							nxt_wctr  = '0;
							nxt_phase = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					word_n[{cur_cnt[2:0], 3'b000} +: 8] =
						word_n[{cur_cnt[2:0], 3'b000} +: 8] | item.data_byte;
					nxt_word = word_n;
					nxt_cnt  = cnt_n;
					last_n   = cnt_n >= cur_plen;
					mod_n    = cnt_n[2:0] - 3'd1;
					if (cnt_n[2:0] == 3'd0 || last_n) begin
						ev_valid  = 1'b1;
						ev.code   = EV_WORD;
						ev.kind   = cur_kind;
						ev.word   = cur_wctr;
						ev.data   = word_n;
						ev.nbytes = {1'b0, mod_n} + 4'd1;
						ev.last   = last_n;
						nxt_word  = '0;
						nxt_wctr  = cur_wctr + 13'd1;
						if (last_n) begin
							nxt_cnt   = '0;
							nxt_phase = PH_TAG;
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
					nxt_phase = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			cnt_q    <= '0;
			tag_q    <= '0;
			plen_q   <= '0;
			word_q   <= '0;
			wctr_q   <= '0;
			ectr_q   <= '0;
			kind_q   <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= nxt_phase;
			cnt_q    <= nxt_cnt;
			tag_q    <= nxt_tag;
			plen_q   <= nxt_plen;
			word_q   <= nxt_word;
			wctr_q   <= nxt_wctr;
			ectr_q   <= nxt_ectr;
			kind_q   <= nxt_kind;
			halted_q <= nxt_halt;
		end
	end

	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev.code == EV_FAULT |=> halted_q)
		else $error("fault transfer did not halt the parser");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && !item.section_start |-> !ev_valid)
		else $error("event raised while halted");

endmodule

// File: rtl/tlvp_fifo.sv
// ----------------------------------------------------------------------------
// tlvp_fifo
// Short event queue between parser and output stage.
// ----------------------------------------------------------------------------
module tlvp_fifo import tlvp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  tlvp_ev_t wr_data,
	input  logic     rd_en,
	output tlvp_ev_t rd_data,
	output logic     full,
	output logic     empty
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);

	tlvp_ev_t        mem_q [FIFO_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("event queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("event queue underflow");

endmodule

// File: rtl/tlvp_back.sv
// ----------------------------------------------------------------------------
// tlvp_back
// Output stage: expands queued events into result items and holds the
// oldest one until the receiver takes it.
// ----------------------------------------------------------------------------
module tlvp_back import tlvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fifo_empty,
	input  tlvp_ev_t  fifo_data,
	output logic      fifo_rd,
	input  logic      pop,
	output logic      empty,
	output tlvp_out_t result
);

	logic      valid_q;
	tlvp_out_t res_q;
	tlvp_out_t fmt;

	assign fifo_rd = !fifo_empty && (!valid_q || pop);
	assign empty   = !valid_q;
	assign result  = res_q;

	always_comb begin
		fmt              = '0;
		fmt.entry_number = fifo_data.entry;
		fmt.record_kind  = fifo_data.kind;
		fmt.record_last  = 1'b1;
		unique case (fifo_data.code)
			EV_LEN: begin
				fmt.word_data   = fifo_data.data;
				fmt.valid_bytes = 4'd4;
			end
			EV_WORD: begin
				fmt.word_number = fifo_data.word;
				fmt.word_data   = fifo_data.data;
				fmt.valid_bytes = fifo_data.nbytes;
				fmt.record_last = fifo_data.last;
			end
			EV_END: begin
				fmt.section_done = fifo_data.done;
			end
			EV_FAULT: begin
				fmt.fault_code = fifo_data.fault;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fifo_rd) begin
			res_q <= fmt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fifo_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q && !fifo_empty |=> valid_q)
		else $error("output register not refilled from waiting event");

endmodule

// File: rtl/tag_length_value_record_parser_core.sv
// ----------------------------------------------------------------------------
// tag_length_value_record_parser_core
// Program-information section parser: bytes in, tagged payload words out.
// ----------------------------------------------------------------------------
// Input channel: push/full carry one section byte per transfer, with
// section_start marking the first byte of a section. Result channel:
// empty/pop present the oldest result word; it transfers when pop is high
// and empty is low. cfg_we/cfg_wdata write the expected entry count.
// Throughput is one byte per cycle while full is low: the parser updates its phase
// machine on every accepted byte and raises at most one event. The event a
// byte raises is written into the event queue at the edge that takes the
// byte; the output register loads it from there when it is empty or popped.
// When the receiver stalls, events collect in a 4-deep queue behind the
// output register; full rises once that queue is full and holds back every
// byte, including bytes that would raise no result. Reset empties the queue
// and output register, clears the entry count and puts the parser at the
// start of a section.
// ----------------------------------------------------------------------------
module tag_length_value_record_parser_core import tlvp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tlvp_in_t         item,
	output logic             empty,
	input  logic             pop,
	output tlvp_out_t        result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic     accept;
	logic     ev_valid;
	tlvp_ev_t ev;
	tlvp_ev_t q_data;
	logic     q_empty;
	logic     q_rd;

	assign accept = push && !full;

	tlvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ev_valid  (ev_valid),
		.ev        (ev)
	);

	tlvp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_valid),
		.wr_data (ev),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	tlvp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (q_empty),
		.fifo_data  (q_data),
		.fifo_rd    (q_rd),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
